@@ rtl/pmc_pkg.sv @@
// ----------------------------------------------------------------------------
// pmc_pkg
// Shared types and constants for the probe request unique address counter:
// frame control decode fields, result status codes, controller states and
// the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package pmc_pkg;

    // Default number of address table entries.
    localparam int TABLE_DEPTH_DEF = 512;

    // Field widths fixed by the interface.
    localparam int FC_W    = 16;
    localparam int ADDR_W  = 48;
    localparam int UCOUNT_W = 10;

    // Frame control decode: type in bits 3:2, subtype in bits 7:4.
    localparam int FC_TYPE_LSB    = 2;
    localparam int FC_TYPE_MSB    = 3;
    localparam int FC_SUBTYPE_LSB = 4;
    localparam int FC_SUBTYPE_MSB = 7;
    localparam logic [1:0] TYPE_MGMT     = 2'h0;
    localparam logic [3:0] SUBTYPE_PROBE = 4'h4;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_IGNORED   = 2'd0,
        ST_ADDED     = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SEARCH
    } state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic    load;    // capture the incoming item and restart the scan
        logic    scan;    // issue the next table read
        logic    write;   // append the address at the current count
        logic    finish;  // register a result with the given code
        status_t code;
    } cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic probe;      // captured frame is a management probe request
        logic match;      // table data read last cycle equals the address
        logic scan_done;  // all stored entries read and compared
        logic room;       // table has at least one free entry
    } sts_t;

endpackage

@@ rtl/probe_request_unique_mac_counter.sv @@
// Each accepted item is decoded; for a probe request the stored addresses are
// then read and compared one by one until a duplicate is found or all are
// read, while any other frame goes straight to its result.
// A new item is taken only after the last one is decided; the linear scan over
// the single read port of the address table sets the pace of the items.
// Reset clears the count and all control, not the table; done cannot stall.
// ----------------------------------------------------------------------------
// probe_request_unique_mac_counter
// Counts distinct transmitter addresses of 802.11 probe request frames,
// storing each new address in a table and reporting a per-item status.
// ----------------------------------------------------------------------------
module probe_request_unique_mac_counter
    import pmc_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [FC_W-1:0]     frame_control,
    input  logic [ADDR_W-1:0]   source_address,
    output logic                done,
    output logic [1:0]          status,
    output logic [UCOUNT_W-1:0] unique_count
);

    cmd_t cmd;
    sts_t sts;

    // Sequencer.
    pmc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Table, scan and result registers.
    pmc_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .frame_control  (frame_control),
        .source_address (source_address),
        .sts            (sts),
        .done           (done),
        .status         (status),
        .unique_count   (unique_count)
    );

    // A result is only shown once the controller is back to accepting items.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // An append needs a free entry and no matching stored address.
    a_write_legal: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |-> (sts.room && !sts.match))
        else $error("append into full table or over a duplicate");

    // Every finish command produces a strobe in the following cycle.
    a_finish_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> done)
        else $error("finish without result strobe");

endmodule

@@ rtl/pmc_ctrl.sv @@
// ----------------------------------------------------------------------------
// pmc_ctrl
// Controller for the unique address counter. Sequences decode, the linear
// table search and the final append or drop decision for each item.
// ----------------------------------------------------------------------------
module pmc_ctrl
    import pmc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  sts_t sts,
    output cmd_t cmd,
    output logic busy
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '{load: 1'b0, scan: 1'b0, write: 1'b0, finish: 1'b0,
                       code: ST_IGNORED};
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.probe)
                begin
                    state_next = S_SEARCH;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    cmd.code   = ST_IGNORED;
                    state_next = S_IDLE;
                end
            end
            S_SEARCH:
            begin
                if (sts.match)
                begin
                    cmd.finish = 1'b1;
                    cmd.code   = ST_DUPLICATE;
                    state_next = S_IDLE;
                end
                else if (sts.scan_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                    if (sts.room)
                    begin
                        cmd.write = 1'b1;
                        cmd.code  = ST_ADDED;
                    end
                    else
                    begin
                        cmd.code = ST_FULL;
                    end
                end
                else
                begin
                    cmd.scan = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

@@ rtl/pmc_datapath.sv @@
// ----------------------------------------------------------------------------
// pmc_datapath
// Datapath for the unique address counter: captured item, address table
// memory with a registered read port, scan pointer, stored count and the
// result registers.
// ----------------------------------------------------------------------------
module pmc_datapath
    import pmc_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    input  logic [FC_W-1:0]     frame_control,
    input  logic [ADDR_W-1:0]   source_address,
    output sts_t                sts,
    output logic                done,
    output logic [1:0]          status,
    output logic [UCOUNT_W-1:0] unique_count
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    logic [ADDR_W-1:0]   mem [TABLE_DEPTH];
    logic [ADDR_W-1:0]   addr_reg;
    logic                probe_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [CW-1:0]       idx_reg;
    logic [ADDR_W-1:0]   rd_data_reg;
    logic                rd_valid_reg;
    logic                rd_en;
    logic                done_reg;
    status_t             status_reg;
    logic [UCOUNT_W-1:0] unique_count_reg;
    logic                probe_in;

    // Probe request decode on the incoming frame control word.
    assign probe_in =
        (frame_control[FC_TYPE_MSB:FC_TYPE_LSB] == TYPE_MGMT) &&
        (frame_control[FC_SUBTYPE_MSB:FC_SUBTYPE_LSB] == SUBTYPE_PROBE);

    // A read is issued while entries below the count remain unread.
    assign rd_en      = cmd.scan && (idx_reg != count_reg);
    assign count_next = cmd.write ? (count_reg + 1'b1) : count_reg;

    // Captured item payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            addr_reg  <= source_address;
            probe_reg <= probe_in;
        end
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            mem[count_reg[AW-1:0]] <= addr_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[idx_reg[AW-1:0]];
        end
    end

    // Scan pointer, read valid flag and stored count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            rd_valid_reg <= 1'b0;
            count_reg    <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.load)
            begin
                idx_reg      <= '0;
                rd_valid_reg <= 1'b0;
            end
            else if (cmd.scan)
            begin
                rd_valid_reg <= rd_en;
                if (rd_en)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
        end
    end

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status_reg       <= cmd.code;
            unique_count_reg <= UCOUNT_W'(count_next);
        end
    end

    // Status toward the controller.
    assign sts.probe     = probe_reg;
    assign sts.match     = rd_valid_reg && (rd_data_reg == addr_reg);
    assign sts.scan_done = !rd_valid_reg && (idx_reg == count_reg);
    assign sts.room      = (count_reg < DEPTH_C);

    assign done         = done_reg;
    assign status       = status_reg;
    assign unique_count = unique_count_reg;

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the probe request unique address counter. Frames
// are sent through the start/busy command handshake while a local predictor
// tracks the table of seen addresses and queues the status and count that
// each item must produce; every done strobe is checked against the oldest
// queued entry. Directed items cover frame decode, duplicates and a full
// table, and random traffic grows the table under varied sender idling.
// ----------------------------------------------------------------------------
module testbench;

    import pmc_pkg::*;

    localparam int TABLE_DEPTH    = TABLE_DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 8;

    // Expected outcome of one frame.
    typedef struct {
        status_t               status;
        logic [UCOUNT_W-1:0]   count;
    } mac_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [FC_W-1:0]     frame_control = '0;
    logic [ADDR_W-1:0]   source_address = '0;
    logic                done;
    logic [1:0]          status;
    logic [UCOUNT_W-1:0] unique_count;

    // Predictor state: a copy of the address table and its fill level.
    logic [ADDR_W-1:0]   seen_table [TABLE_DEPTH];
    int                  seen_count = 0;
    mac_result_t         pending_results [$];

    int                  sender_idle_pct = 0;
    int                  errors = 0;
    int                  idle_cycles = 0;

    probe_request_unique_mac_counter #(
        .TABLE_DEPTH    (TABLE_DEPTH)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .frame_control  (frame_control),
        .source_address (source_address),
        .done           (done),
        .status         (status),
        .unique_count   (unique_count)
    );

    // Clock generation.
    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Decode the frame, update the table copy and queue the expected result.
    function automatic void predict_frame(input logic [FC_W-1:0] fc,
                                          input logic [ADDR_W-1:0] addr);
        mac_result_t res;
        bit          found;
        int          i;
        found = 1'b0;
        if (fc[FC_TYPE_MSB:FC_TYPE_LSB] != TYPE_MGMT ||
            fc[FC_SUBTYPE_MSB:FC_SUBTYPE_LSB] != SUBTYPE_PROBE)
        begin
            res.status = ST_IGNORED;
        end
        else
        begin
            for (i = 0; i < seen_count; i++)
            begin
                if (seen_table[i] == addr)
                    found = 1'b1;
            end
            if (found)
                res.status = ST_DUPLICATE;
            else if (seen_count < TABLE_DEPTH)
            begin
                seen_table[seen_count] = addr;
                seen_count++;
                res.status = ST_ADDED;
            end
            else
                res.status = ST_FULL;
        end
        res.count = seen_count[UCOUNT_W-1:0];
        pending_results.push_back(res);
    endfunction

    // Frame control word with random bits outside type and subtype that decodes as a probe request.
    function automatic logic [FC_W-1:0] probe_fc();
        logic [FC_W-1:0] fc;
        fc = FC_W'($urandom);
        fc[FC_TYPE_MSB:FC_TYPE_LSB] = TYPE_MGMT;
        fc[FC_SUBTYPE_MSB:FC_SUBTYPE_LSB] = SUBTYPE_PROBE;
        return fc;
    endfunction

    // Send one item: optional idle cycles, then hold start until it is taken.
    task automatic send_frame(input logic [FC_W-1:0] fc, input logic [ADDR_W-1:0] addr);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        frame_control  <= fc;
        source_address <= addr;
        start          <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predict_frame(fc, addr);
    endtask

    // Frames that are not probe requests, including near misses on type and subtype.
    task automatic test_ignored_frames();
        send_frame(16'h0000, 48'h0000_0000_0000);
        send_frame(16'hFFFF, 48'hFFFF_FFFF_FFFF);
        send_frame(16'h0048, 48'h0200_0000_0001);
        send_frame(16'h0044, 48'h0200_0000_0002);
        send_frame(16'h0050, 48'h0200_0000_0003);
        send_frame(16'h00B4, 48'h0200_0000_0004);
    endtask

    // First additions, duplicates and addresses that differ in a single bit.
    task automatic test_probe_basics();
        send_frame(16'h0040, 48'h0000_0000_0000);
        send_frame(16'hFF43, 48'hFFFF_FFFF_FFFF);
        send_frame(16'h0040, 48'h0000_0000_0000);
        send_frame(16'hA5C3, 48'hFFFF_FFFF_FFFF);
        send_frame(16'h0040, 48'h8000_0000_0000);
        send_frame(16'h0040, 48'h0000_0000_0001);
        // An ignored frame must not store its address.
        send_frame(16'h004C, 48'h1234_5678_9ABC);
        send_frame(16'h0040, 48'h1234_5678_9ABC);
        send_frame(16'h0040, 48'h1234_5678_9ABD);
    endtask

    // Random traffic: mostly probe requests with new or stored addresses, some noise.
    task automatic test_random_traffic(input int idle_pct, input int item_target);
        int              counted;
        int              pick;
        logic [FC_W-1:0] fc;
        logic [ADDR_W-1:0] addr;
        sender_idle_pct = idle_pct;
        counted = 0;
        while (counted < item_target)
        begin
            pick = $urandom_range(99);
            fc = probe_fc();
            addr = ADDR_W'({$urandom, $urandom});
            if (pick < 20)
                fc = FC_W'($urandom);
            else if (pick < 35 && seen_count > 0)
                addr = seen_table[$urandom_range(seen_count - 1)];
            else if (pick < 40 && seen_count > 0)
                addr = seen_table[$urandom_range(seen_count - 1)]
                       ^ (48'h1 << $urandom_range(ADDR_W - 1));
            counted++;
            send_frame(fc, addr);
        end
    endtask

    // Fill the table, then check dropping, duplicates in a full table and noise.
    task automatic test_full_table();
        logic [ADDR_W-1:0] last_addr;
        while (seen_count < TABLE_DEPTH)
            send_frame(probe_fc(), ADDR_W'({$urandom, $urandom}));
        last_addr = seen_table[TABLE_DEPTH - 1];
        send_frame(16'h0040, 48'hFEDC_BA98_7654);
        send_frame(16'h0040, seen_table[0]);
        send_frame(16'h0040, last_addr);
        send_frame(16'h0040, last_addr ^ 48'h8000_0000_0000);
        send_frame(16'h0080, 48'hFEDC_BA98_7654);
    endtask

    // Result checker: every strobe must match the oldest expected result.
    always @(posedge clk)
    begin
        mac_result_t exp_res;
        if (rst_n && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result: status %0d, count %0d",
                         $time, status, unique_count);
                errors++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (status !== exp_res.status)
                begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, exp_res.status, status);
                    errors++;
                end
                if (unique_count !== exp_res.count)
                begin
                    $display("%0t: unique_count mismatch: expected %0d, actual %0d",
                             $time, exp_res.count, unique_count);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end the run if no item and no result moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done === 1'b1)
            idle_cycles <= 0;
        else if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("probe_request_unique_mac_counter regression: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Test sequence.
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_ignored_frames();
        test_probe_basics();
        test_random_traffic(32, 380);
        test_random_traffic(67, 380);
        test_full_table();
        test_random_traffic(0, 380);

        // Let the last items drain before judging the run.
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("probe_request_unique_mac_counter regression: pass");
        else
            $display("probe_request_unique_mac_counter regression: fail");
        $finish;
    end

endmodule
